/* sv/fire_heat_map_engine_defines.svh */
// assertion macros for the fire heat map engine
// used by fhm_seq and fire_heat_map_engine, no other dependencies
`ifndef FIRE_HEAT_MAP_ENGINE_DEFINES_SVH
`define FIRE_HEAT_MAP_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define FHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fhm assertion failed");
`define FHM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fhm assertion failed");
`else
`define FHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FHM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/fhm_pkg.sv */
// fhm_pkg: payload structs, shared-unit request type, sequencer states and constants
// no dependencies
`default_nettype none

package fhm_pkg;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int CFG_W  = 7;
  localparam int CIDX_W = 2;
  localparam int ACC_W  = 16;
  localparam int ALU_W  = 17;

  localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] GRID_RESET = 7'd16;

  localparam logic [1:0] OP_COOL    = 2'd0;
  localparam logic [1:0] OP_DIFFUSE = 2'd1;
  localparam logic [1:0] OP_IGNITE  = 2'd2;
  localparam logic [1:0] OP_RENDER  = 2'd3;

  localparam logic [3:0] IGNITE_MIN = 4'd5;
  localparam logic [7:0] HEAT_SCALE = 8'd191;
  localparam logic [7:0] HEAT_BIAS  = 8'd127;
  localparam logic [7:0] CELL_MAX   = 8'hff;

  typedef struct packed {
    logic [1:0]       op;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [7:0]       amount;
    logic [3:0]       ignite_roll;
    logic [7:0]       offset_col;
    logic [7:0]       offset_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] led_row;
    logic [8:0] led_col;
  } out_item_t;

  typedef enum logic {
    ALU_MAC,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] c;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_D_ADDR,
    S_D_READ,
    S_D_ACC,
    S_D_WADDR,
    S_D_WRITE,
    S_C_ADDR,
    S_C_READ,
    S_C_CALC,
    S_R_MOD,
    S_R_ADDR,
    S_R_READ,
    S_R_MUL,
    S_R_OUT
  } state_t;

endpackage

`default_nettype wire

/* sv/fire_heat_map_engine.sv */
// fire_heat_map_engine: top level, size registers, output register and unit wiring
// depends on fhm_pkg, fhm_grid_ram, fhm_alu, fhm_seq and the assertion macro header
//
// Usage: items arrive on in_valid/in_ready/in_data, one transfer per item. Cool and
// ignite change one cell and give no result; diffuse runs the upward pass over all
// rows above row 0 and gives no result; render gives one transfer on out_valid/out_ready/
// out_data. Grid size is set through cfg_valid/cfg_index/cfg_data (cfg_ready always
// high), index 0 width, index 1 height, both 16 after reset; write only when idle.
// Steps: cool and ignite read one cell and write it back; render runs a 6-step remainder
// on the shared unit, a memory read and a multiply; diffuse reads four neighbours and
// writes one cell per grid cell; all use the single shared arithmetic unit and the one
// memory read port. in_ready is low while an item is in work.
// Reset: synchronous; afterwards the grid is cleared one cell a cycle, all
// MAX_WIDTH * MAX_HEIGHT cells (4096 by default), with in_ready low.
// Stall: a render result sits in the output register; the next item is still taken,
// and a following render waits in the engine until the register is free.
`default_nettype none
`include "fire_heat_map_engine_defines.svh"

module fire_heat_map_engine #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fhm_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fhm_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fhm_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [fhm_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [fhm_pkg::CFG_W-1:0] gw_r, gw_nxt, gh_r, gh_nxt;
  logic [fhm_pkg::CFG_W-1:0] used_w, used_h;
  logic                      out_valid_r, out_valid_nxt;
  fhm_pkg::out_item_t        out_data_r;
  logic                      out_free;
  logic                      res_load;
  fhm_pkg::out_item_t        res_data;
  fhm_pkg::alu_req_t         alu_req;
  logic [fhm_pkg::ALU_W-1:0] alu_res;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [7:0]                ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    gw_nxt = gw_r;
    gh_nxt = gh_r;
    if (cfg_valid) begin
      case (cfg_index)
        fhm_pkg::CFG_GRID_WIDTH:  gw_nxt = cfg_data;
        fhm_pkg::CFG_GRID_HEIGHT: gh_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as one, above the maximum saturates
  always_comb begin
    used_w = gw_r;
    if (gw_r == 7'd0) begin
      used_w = 7'd1;
    end else if (int'(gw_r) > MAX_WIDTH) begin
      used_w = 7'(MAX_WIDTH);
    end
    used_h = gh_r;
    if (gh_r == 7'd0) begin
      used_h = 7'd1;
    end else if (int'(gh_r) > MAX_HEIGHT) begin
      used_h = 7'(MAX_HEIGHT);
    end
  end

  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r        <= fhm_pkg::GRID_RESET;
      gh_r        <= fhm_pkg::GRID_RESET;
      out_valid_r <= 1'b0;
    end else begin
      gw_r        <= gw_nxt;
      gh_r        <= gh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fhm_grid_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fhm_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  fhm_seq #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .used_w    (used_w),
    .used_h    (used_h),
    .out_free  (out_free),
    .res_load  (res_load),
    .res_data  (res_data),
    .alu_req   (alu_req),
    .alu_res   (alu_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  `FHM_ASSERT_NXT(a_load_shows, clk, rst_n, res_load, (out_valid_r && out_data_r == $past(res_data)))

endmodule

`default_nettype wire

/* sv/fhm_grid_ram.sv */
// fhm_grid_ram: heat grid storage, one write port and one registered read port
// no dependencies
`default_nettype none

module fhm_grid_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/fhm_alu.sv */
// fhm_alu: shared arithmetic unit, multiply-add or subtract with borrow in the top bit
// depends on fhm_pkg
`default_nettype none

module fhm_alu (
  input  wire fhm_pkg::alu_req_t         req,
  output logic [fhm_pkg::ALU_W-1:0]      res
);

  logic [15:0] prod;

  assign prod = 16'(req.a) * 16'(req.b);

  always_comb begin
    case (req.op)
      fhm_pkg::ALU_SUB: res = {1'b0, req.c} - {9'd0, req.a};
      default:          res = {1'b0, prod} + {1'b0, req.c};
    endcase
  end

endmodule

`default_nettype wire

/* sv/fhm_seq.sv */
// fhm_seq: sequencer driving the shared unit and the grid memory for all item kinds
// depends on fhm_pkg (which holds the shared-unit request type) and the assertion macro header
`default_nettype none
`include "fire_heat_map_engine_defines.svh"

module fhm_seq #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire fhm_pkg::in_item_t           in_data,
  output logic                             in_ready,
  input  wire logic [fhm_pkg::CFG_W-1:0]   used_w,
  input  wire logic [fhm_pkg::CFG_W-1:0]   used_h,
  input  wire logic                        out_free,
  output logic                             res_load,
  output fhm_pkg::out_item_t               res_data,
  output fhm_pkg::alu_req_t                alu_req,
  input  wire logic [fhm_pkg::ALU_W-1:0]   alu_res,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output logic [7:0]                       ram_wdata,
  output logic [AW-1:0]                    ram_raddr,
  input  wire logic [7:0]                  ram_rdata
);

  fhm_pkg::state_t   state_r, state_nxt;
  fhm_pkg::in_item_t item_r, item_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [fhm_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [fhm_pkg::CFG_W-1:0] x_r, x_nxt;
  logic [fhm_pkg::CFG_W-1:0] y_r, y_nxt;
  logic [1:0]        tap_r, tap_nxt;
  logic [fhm_pkg::CFG_W-1:0] rem_r, rem_nxt;
  logic [2:0]        idx_r, idx_nxt;

  logic [fhm_pkg::CFG_W-1:0] ym1, yb2, xl, xr, tap_x, tap_y, ry;
  logic [7:0]        cand;
  logic [16:0]       qsum;
  logic [7:0]        t192;
  logic [7:0]        ramp;

  // neighbour coordinates, wrapping in x and clamping in y
  always_comb begin
    ym1 = y_r - 7'd1;
    yb2 = (y_r >= 7'd2) ? (y_r - 7'd2) : 7'd0;
    xl  = (x_r == 7'd0) ? (used_w - 7'd1) : (x_r - 7'd1);
    xr  = ((x_r + 7'd1) == used_w) ? 7'd0 : (x_r + 7'd1);
    case (tap_r)
      2'd0:    begin tap_x = x_r; tap_y = ym1; end
      2'd1:    begin tap_x = x_r; tap_y = yb2; end
      2'd2:    begin tap_x = xl;  tap_y = ym1; end
      default: begin tap_x = xr;  tap_y = ym1; end
    endcase
    ry = ({1'b0, item_r.row} < used_h) ? (used_h - 7'd1 - {1'b0, item_r.row}) : 7'd0;
    cand = {rem_r, item_r.column[idx_r]};
  end

  // heat ramp: divide by 255 through the reciprocal identity
  always_comb begin
    qsum = {1'b0, acc_r} + 17'd1 + {9'd0, acc_r[15:8]};
    t192 = qsum[15:8];
    ramp = {t192[5:0], 2'b00};
    case (t192[7:6])
      2'd0: begin
        res_data.red = ramp; res_data.green = 8'd0; res_data.blue = 8'd0;
      end
      2'd1: begin
        res_data.red = fhm_pkg::CELL_MAX; res_data.green = ramp; res_data.blue = 8'd0;
      end
      default: begin
        res_data.red   = fhm_pkg::CELL_MAX;
        res_data.green = fhm_pkg::CELL_MAX;
        res_data.blue  = ramp;
      end
    endcase
    res_data.led_row = {1'b0, item_r.offset_row} + {3'd0, item_r.row};
    res_data.led_col = {1'b0, item_r.offset_col} + {3'd0, item_r.column};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fhm_pkg::S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    addr_r <= addr_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    tap_r  <= tap_nxt;
    rem_r  <= rem_nxt;
    idx_r  <= idx_nxt;
  end

  assign ram_raddr = addr_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    item_nxt  = item_r;
    addr_nxt  = addr_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    tap_nxt   = tap_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = 8'd0;
    alu_req.op = fhm_pkg::ALU_MAC;
    alu_req.a  = 8'd0;
    alu_req.b  = 8'd0;
    alu_req.c  = 16'd0;
    case (state_r)
      fhm_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = fhm_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      fhm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.op)
            fhm_pkg::OP_COOL: begin
              if (({1'b0, in_data.column} < used_w) && ({1'b0, in_data.row} < used_h)) begin
                state_nxt = fhm_pkg::S_C_ADDR;
              end
            end
            fhm_pkg::OP_IGNITE: begin
              if (({1'b0, in_data.column} < used_w) &&
                  (in_data.ignite_roll > fhm_pkg::IGNITE_MIN)) begin
                state_nxt = fhm_pkg::S_C_ADDR;
              end
            end
            fhm_pkg::OP_DIFFUSE: begin
              x_nxt   = 7'd0;
              y_nxt   = used_h - 7'd1;
              tap_nxt = 2'd0;
              if (used_h > 7'd1) begin
                state_nxt = fhm_pkg::S_D_ADDR;
              end
            end
            default: begin
              rem_nxt   = 7'd0;
              idx_nxt   = 3'(fhm_pkg::COL_W - 1);
              state_nxt = fhm_pkg::S_R_MOD;
            end
          endcase
        end
      end
      fhm_pkg::S_D_ADDR: begin
        alu_req.a = {1'b0, tap_y};
        alu_req.b = {1'b0, used_w};
        alu_req.c = {9'd0, tap_x};
        addr_nxt  = AW'(alu_res);
        state_nxt = fhm_pkg::S_D_READ;
      end
      fhm_pkg::S_D_READ: begin
        state_nxt = fhm_pkg::S_D_ACC;
      end
      fhm_pkg::S_D_ACC: begin
        alu_req.a = ram_rdata;
        alu_req.b = 8'd1;
        alu_req.c = (tap_r == 2'd0) ? 16'd0 : acc_r;
        acc_nxt   = alu_res[fhm_pkg::ACC_W-1:0];
        tap_nxt   = tap_r + 2'd1;
        state_nxt = (tap_r == 2'd3) ? fhm_pkg::S_D_WADDR : fhm_pkg::S_D_ADDR;
      end
      fhm_pkg::S_D_WADDR: begin
        alu_req.a = {1'b0, y_r};
        alu_req.b = {1'b0, used_w};
        alu_req.c = {9'd0, x_r};
        addr_nxt  = AW'(alu_res);
        state_nxt = fhm_pkg::S_D_WRITE;
      end
      fhm_pkg::S_D_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = acc_r[9:2];
        tap_nxt   = 2'd0;
        state_nxt = fhm_pkg::S_D_ADDR;
        if (y_r == 7'd1) begin
          if ((x_r + 7'd1) == used_w) begin
            state_nxt = fhm_pkg::S_IDLE;
          end else begin
            x_nxt = x_r + 7'd1;
            y_nxt = used_h - 7'd1;
          end
        end else begin
          y_nxt = y_r - 7'd1;
        end
      end
      fhm_pkg::S_C_ADDR: begin
        alu_req.a = (item_r.op == fhm_pkg::OP_COOL) ? {2'd0, item_r.row} : 8'd0;
        alu_req.b = {1'b0, used_w};
        alu_req.c = {10'd0, item_r.column};
        addr_nxt  = AW'(alu_res);
        state_nxt = fhm_pkg::S_C_READ;
      end
      fhm_pkg::S_C_READ: begin
        state_nxt = fhm_pkg::S_C_CALC;
      end
      fhm_pkg::S_C_CALC: begin
        ram_we = 1'b1;
        if (item_r.op == fhm_pkg::OP_COOL) begin
          alu_req.op = fhm_pkg::ALU_SUB;
          alu_req.a  = item_r.amount;
          alu_req.c  = {8'd0, ram_rdata};
          ram_wdata  = alu_res[16] ? 8'd0 : alu_res[7:0];
        end else begin
          alu_req.a = ram_rdata;
          alu_req.b = 8'd1;
          alu_req.c = {8'd0, item_r.amount};
          ram_wdata = alu_res[8] ? fhm_pkg::CELL_MAX : alu_res[7:0];
        end
        state_nxt = fhm_pkg::S_IDLE;
      end
      fhm_pkg::S_R_MOD: begin
        // restoring remainder, one column bit per cycle
        alu_req.op = fhm_pkg::ALU_SUB;
        alu_req.a  = {1'b0, used_w};
        alu_req.c  = {8'd0, cand};
        rem_nxt    = alu_res[16] ? cand[6:0] : alu_res[6:0];
        idx_nxt    = idx_r - 3'd1;
        if (idx_r == 3'd0) begin
          state_nxt = fhm_pkg::S_R_ADDR;
        end
      end
      fhm_pkg::S_R_ADDR: begin
        alu_req.a = {1'b0, ry};
        alu_req.b = {1'b0, used_w};
        alu_req.c = {9'd0, rem_r};
        addr_nxt  = AW'(alu_res);
        state_nxt = fhm_pkg::S_R_READ;
      end
      fhm_pkg::S_R_READ: begin
        state_nxt = fhm_pkg::S_R_MUL;
      end
      fhm_pkg::S_R_MUL: begin
        alu_req.a = ram_rdata;
        alu_req.b = fhm_pkg::HEAT_SCALE;
        alu_req.c = {8'd0, fhm_pkg::HEAT_BIAS};
        acc_nxt   = alu_res[fhm_pkg::ACC_W-1:0];
        state_nxt = fhm_pkg::S_R_OUT;
      end
      fhm_pkg::S_R_OUT: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = fhm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fhm_pkg::S_IDLE;
      end
    endcase
  end

  `FHM_ASSERT_IMP(a_load_free, clk, rst_n, res_load, out_free)
  `FHM_ASSERT_IMP(a_rem_below_w, clk, rst_n, state_r == fhm_pkg::S_R_MOD, rem_r < used_w)
  `FHM_ASSERT_IMP(a_diff_row, clk, rst_n, state_r == fhm_pkg::S_D_ADDR, y_r != 7'd0)
  `FHM_ASSERT_IMP(a_we_state, clk, rst_n, ram_we, (state_r == fhm_pkg::S_CLEAR || state_r == fhm_pkg::S_D_WRITE || state_r == fhm_pkg::S_C_CALC))

endmodule

`default_nettype wire

/* dv/tb_fire_heat_map_engine.sv */
// testbench for fire_heat_map_engine: cell, diffuse and render items against a local heat grid model
// depends on fhm_pkg and the fire_heat_map_engine rtl, self-checking, no files or arguments
module tb_fire_heat_map_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import fhm_pkg::*;

  localparam int GRID_MAX_W  = 64;
  localparam int GRID_MAX_H  = 64;
  localparam int CELL_CYCLES = 14;
  localparam int CYCLE_LIMIT = 4000000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  logic [7:0]       heat_cells [GRID_MAX_W*GRID_MAX_H];
  logic [CFG_W-1:0] width_reg  = GRID_RESET;
  logic [CFG_W-1:0] height_reg = GRID_RESET;
  out_item_t        expected_pixels [$];
  int unsigned      err_count    = 0;
  int unsigned      cycle_count  = 0;
  int unsigned      sink_hold    = 0;
  bit               src_idle_en  = 1'b0;
  bit               sink_idle_en = 1'b0;

  fire_heat_map_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned cols_in_use();
    if (width_reg == 0) return 1;
    if (width_reg > GRID_MAX_W) return GRID_MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned rows_in_use();
    if (height_reg == 0) return 1;
    if (height_reg > GRID_MAX_H) return GRID_MAX_H;
    return height_reg;
  endfunction

  function automatic void spread_heat();
    int unsigned w, h, x, y, left, right, low2, sum;
    w = cols_in_use();
    h = rows_in_use();
    for (x = 0; x < w; x++) begin
      left  = (x == 0) ? w - 1 : x - 1;
      right = (x + 1 == w) ? 0 : x + 1;
      for (y = h - 1; y > 0; y--) begin
        low2 = (y >= 2) ? y - 2 : 0;
        sum  = heat_cells[(y-1)*w+x] + heat_cells[low2*w+x]
             + heat_cells[(y-1)*w+left] + heat_cells[(y-1)*w+right];
        heat_cells[y*w+x] = 8'(sum >> 2);
      end
    end
  endfunction

  function automatic void advance_heat_grid(input in_item_t it);
    int unsigned w, h, col, row, amt, idx, v, x, y, t192, ramp;
    out_item_t   pixel;
    w   = cols_in_use();
    h   = rows_in_use();
    col = it.column;
    row = it.row;
    amt = it.amount;
    case (it.op)
      OP_COOL: begin
        if (col < w && row < h) begin
          idx = row * w + col;
          v   = heat_cells[idx];
          heat_cells[idx] = (v > amt) ? 8'(v - amt) : 8'd0;
        end
      end
      OP_DIFFUSE: spread_heat();
      OP_IGNITE: begin
        if (col < w && it.ignite_roll > IGNITE_MIN) begin
          v = heat_cells[col] + amt;
          heat_cells[col] = (v > CELL_MAX) ? CELL_MAX : 8'(v);
        end
      end
      default: begin
        x    = col % w;
        y    = (row < h) ? h - 1 - row : 0;
        v    = heat_cells[y*w+x];
        t192 = (v * HEAT_SCALE + HEAT_BIAS) / CELL_MAX;
        ramp = (t192 & 63) << 2;
        if (t192 < 64) begin
          pixel.red   = 8'(ramp);
          pixel.green = 8'd0;
          pixel.blue  = 8'd0;
        end else if (t192 < 128) begin
          pixel.red   = CELL_MAX;
          pixel.green = 8'(ramp);
          pixel.blue  = 8'd0;
        end else begin
          pixel.red   = CELL_MAX;
          pixel.green = CELL_MAX;
          pixel.blue  = 8'(ramp);
        end
        pixel.led_row = 9'(int'(it.offset_row) + row);
        pixel.led_col = 9'(int'(it.offset_col) + col);
        expected_pixels.push_back(pixel);
      end
    endcase
  endfunction

  function automatic in_item_t heat_item(input logic [1:0] op, input int unsigned col,
                                         input int unsigned row, input int unsigned amt,
                                         input int unsigned roll, input int unsigned ocol,
                                         input int unsigned orow);
    in_item_t it;
    it.op          = op;
    it.column      = 6'(col);
    it.row         = 6'(row);
    it.amount      = 8'(amt);
    it.ignite_roll = 4'(roll);
    it.offset_col  = 8'(ocol);
    it.offset_row  = 8'(orow);
    return it;
  endfunction

  function automatic in_item_t random_heat_item(input bit allow_spread);
    in_item_t    it;
    int unsigned pick, w, h;
    w    = cols_in_use();
    h    = rows_in_use();
    pick = $urandom_range(0, 99);
    if (allow_spread && pick < 6) it.op = OP_DIFFUSE;
    else if (pick < 28)           it.op = OP_COOL;
    else if (pick < 58)           it.op = OP_IGNITE;
    else                          it.op = OP_RENDER;
    it.column = ($urandom_range(0, 6) != 0) ? 6'($urandom_range(0, w - 1))
                                            : 6'($urandom_range(0, 63));
    it.row    = ($urandom_range(0, 6) != 0) ? 6'($urandom_range(0, h - 1))
                                            : 6'($urandom_range(0, 63));
    if (it.op == OP_IGNITE && $urandom_range(0, 9) < 7)
      it.amount = 8'($urandom_range(160, 254));
    else if (it.op == OP_COOL && $urandom_range(0, 9) < 7)
      it.amount = 8'($urandom_range(20, 34));
    else
      it.amount = 8'($urandom_range(0, 255));
    it.ignite_roll = 4'($urandom_range(0, 15));
    it.offset_col  = 8'($urandom_range(0, 255));
    it.offset_row  = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic logic [CFG_W-1:0] extreme_size();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd65;
      4:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic note_mismatch(input string field, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    err_count++;
  endtask

  task automatic send_heat_item(input in_item_t it);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_heat_grid(it);
  endtask

  task automatic drain_and_settle();
    int unsigned settle;
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    settle = CELL_CYCLES * cols_in_use() * rows_in_use() + 64;
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = w_raw;
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    height_reg = h_raw;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_cell_ops();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_heat_item(heat_item(OP_RENDER, 0, 0, 0, 0, 0, 0));
    send_heat_item(heat_item(OP_IGNITE, 0, 0, 200, 5, 0, 0));
    send_heat_item(heat_item(OP_IGNITE, 0, 0, 200, 6, 0, 0));
    send_heat_item(heat_item(OP_IGNITE, 0, 0, 255, 15, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 0, 15, 0, 0, 255, 255));
    send_heat_item(heat_item(OP_IGNITE, 16, 0, 100, 9, 0, 0));
    send_heat_item(heat_item(OP_COOL, 0, 0, 0, 0, 0, 0));
    send_heat_item(heat_item(OP_IGNITE, 1, 0, 100, 7, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 1, 63, 0, 0, 255, 255));
    send_heat_item(heat_item(OP_COOL, 1, 0, 255, 0, 0, 0));
    send_heat_item(heat_item(OP_COOL, 63, 63, 10, 0, 0, 0));
    send_heat_item(heat_item(OP_IGNITE, 2, 0, 40, 6, 0, 0));
    send_heat_item(heat_item(OP_IGNITE, 5, 0, 90, 8, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 21, 15, 0, 0, 3, 7));
    send_heat_item(heat_item(OP_RENDER, 2, 15, 0, 0, 0, 0));
    drain_and_settle();
  endtask

  task automatic test_spread_edges();
    send_heat_item(heat_item(OP_DIFFUSE, 0, 0, 0, 0, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 0, 14, 0, 0, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 15, 14, 0, 0, 0, 0));
    drain_and_settle();
  endtask

  task automatic test_size_extremes();
    set_grid(7'd0, 7'd0);
    send_heat_item(heat_item(OP_IGNITE, 0, 0, 77, 6, 0, 0));
    send_heat_item(heat_item(OP_DIFFUSE, 0, 0, 0, 0, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 63, 63, 0, 0, 128, 64));
    drain_and_settle();
    set_grid(7'd127, 7'd127);
    send_heat_item(heat_item(OP_IGNITE, 63, 0, 250, 10, 0, 0));
    send_heat_item(heat_item(OP_DIFFUSE, 0, 0, 0, 0, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 63, 62, 0, 0, 0, 0));
    drain_and_settle();
    set_grid(7'd64, 7'd1);
    send_heat_item(heat_item(OP_DIFFUSE, 0, 0, 0, 0, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 40, 0, 0, 0, 0, 0));
    drain_and_settle();
    set_grid(7'd1, 7'd64);
    send_heat_item(heat_item(OP_IGNITE, 0, 0, 200, 12, 0, 0));
    send_heat_item(heat_item(OP_DIFFUSE, 0, 0, 0, 0, 0, 0));
    send_heat_item(heat_item(OP_RENDER, 0, 62, 0, 0, 0, 0));
    drain_and_settle();
  endtask

  task automatic test_random_phases();
    int unsigned      sent, n, pick, spreads_left;
    logic [CFG_W-1:0] w_raw, h_raw;
    in_item_t         it;
    sent = 0;
    while (sent < 1500) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        w_raw = 7'($urandom_range(1, 12));
        h_raw = 7'($urandom_range(1, 12));
      end else if (pick < 9) begin
        w_raw = extreme_size();
        h_raw = extreme_size();
      end else begin
        w_raw = 7'($urandom_range(13, 127));
        h_raw = 7'($urandom_range(13, 127));
      end
      set_grid(w_raw, h_raw);
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 90);
      spreads_left = (cols_in_use() * rows_in_use() > 256) ? 1 : n;
      repeat (n) begin
        it = random_heat_item(spreads_left != 0);
        if (it.op == OP_DIFFUSE) spreads_left--;
        send_heat_item(it);
      end
      sent += n;
      drain_and_settle();
    end
  endtask

  task automatic test_no_idle_tail();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_grid(7'($urandom_range(4, 12)), 7'($urandom_range(4, 12)));
    repeat (150) send_heat_item(random_heat_item(1'b1));
    drain_and_settle();
  endtask

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      sink_hold <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // pixel transfer check against the oldest prediction
  always @(posedge clk) begin : check_pixels
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("unexpected pixel", out_data, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.red != want.red) note_mismatch("red", out_data.red, want.red);
        if (out_data.green != want.green) note_mismatch("green", out_data.green, want.green);
        if (out_data.blue != want.blue) note_mismatch("blue", out_data.blue, want.blue);
        if (out_data.led_row != want.led_row)
          note_mismatch("led_row", out_data.led_row, want.led_row);
        if (out_data.led_col != want.led_col)
          note_mismatch("led_col", out_data.led_col, want.led_col);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    foreach (heat_cells[i]) heat_cells[i] = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // wait out the clearing pass
    while (!in_ready) @(posedge clk);
    test_cell_ops();
    test_spread_edges();
    test_size_extremes();
    test_random_phases();
    test_no_idle_tail();
    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* fire_heat_map_engine.f */
+incdir+sv
sv/fhm_pkg.sv
sv/fhm_grid_ram.sv
sv/fhm_alu.sv
sv/fhm_seq.sv
sv/fire_heat_map_engine.sv
dv/tb_fire_heat_map_engine.sv
